FILE: design/vra_pkg.sv
package vra_pkg;

   localparam int ADDR_W          = 48;
   localparam int LEN_W           = 34;
   localparam int OUT_W           = 3;
   localparam int CSR_INDEX_W     = 2;
   localparam int RANGE_SLOTS_DEF = 64;
   localparam int PAGE_BYTES      = 4096;
   localparam int PAGE_SHIFT      = $clog2(PAGE_BYTES);

   localparam logic [ADDR_W-1:0] AREA_BASE_RST = 48'h0001_0000_0000;
   localparam logic [ADDR_W-1:0] AREA_END_RST  = 48'h0002_0000_0000;

   typedef enum logic {
      KIND_RESERVE = 1'b0,
      KIND_RELEASE = 1'b1
   } kind_type;

   typedef enum logic [OUT_W-1:0] {
      OUT_RESERVED = 3'd0,
      OUT_NO_SPACE = 3'd1,
      OUT_MERGED   = 3'd2,
      OUT_APPENDED = 3'd3,
      OUT_LEAKED   = 3'd4
   } outcome_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_AREA_BASE = 2'd0,
      CSR_AREA_END  = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] length;
   } range_type;

   // verdict on one table entry for the request in flight
   typedef struct packed {
      logic      hit;
      logic      empties;
      range_type updated;
   } check_type;

endpackage

FILE: design/vra_if.sv
interface vra_req_if;
   logic                            valid;
   logic                            ready;
   logic                            kind;
   logic [vra_pkg::LEN_W-1:0]       request_length;
   logic [vra_pkg::ADDR_W-1:0]      release_address;

   modport source (output valid, kind, request_length, release_address, input ready);
   modport sink   (input valid, kind, request_length, release_address, output ready);
endinterface

interface vra_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [vra_pkg::ADDR_W-1:0]      granted_address;
   logic [vra_pkg::OUT_W-1:0]       outcome;

   modport source (output valid, granted_address, outcome, input ready);
   modport sink   (input valid, granted_address, outcome, output ready);
endinterface

interface vra_csr_if;
   logic                            valid;
   logic                            ready;
   logic [vra_pkg::CSR_INDEX_W-1:0] index;
   logic [vra_pkg::ADDR_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/virtual_range_allocator.sv
// Channel  Direction  Payload
// req      in         kind, request_length, release_address
// rsp      out        granted_address, outcome
// csr      in         index (0 area_base, 1 area_end), data
//
// One transaction at a time. The scan stops at the first entry that hits; when a reserve empties
// a range that is not the last live one, the last live range moves into its slot. No hit reads every live range.
// The scan reads one table entry per cycle from the range memory, which has one read and one write port.
// Reset is synchronous and clears control state; the table is loaded by the
// first request, so no clearing pass is needed.
// A finished result waits in the rsp register; a new request is taken meanwhile.
module virtual_range_allocator #(
   parameter int RANGE_SLOTS = vra_pkg::RANGE_SLOTS_DEF
) (
   input logic        clock,
   input logic        reset,
   vra_req_if.sink    req_chan,
   vra_rsp_if.source  rsp_chan,
   vra_csr_if.sink    csr_chan
);

   localparam int IDX_W = $clog2(RANGE_SLOTS);
   localparam int CNT_W = $clog2(RANGE_SLOTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_DONE
   } state_type;

   function automatic logic [vra_pkg::ADDR_W-1:0] span_of(
      input logic [vra_pkg::LEN_W-1:0] len);
      logic [vra_pkg::LEN_W:0]    sum;
      logic [vra_pkg::ADDR_W-1:0] pages;
      sum   = {1'b0, len} + (vra_pkg::LEN_W + 1)'(vra_pkg::PAGE_BYTES - 1);
      pages = vra_pkg::ADDR_W'(sum >> vra_pkg::PAGE_SHIFT);
      // round up, then add the guard page
      return (pages + vra_pkg::ADDR_W'(1)) << vra_pkg::PAGE_SHIFT;
   endfunction

   state_type                  state_ff, state_in;
   logic                       kind_ff, kind_in;
   logic [vra_pkg::ADDR_W-1:0] span_ff, span_in;
   logic [vra_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [vra_pkg::ADDR_W-1:0] after_ff, after_in;
   logic [CNT_W-1:0]           live_ff, live_in;
   logic                       loaded_ff, loaded_in;
   logic [CNT_W-1:0]           scan_ff, scan_in;
   logic                       chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]           chk_idx_ff, chk_idx_in;
   logic [IDX_W-1:0]           hit_idx_ff, hit_idx_in;
   logic [vra_pkg::ADDR_W-1:0] res_granted_ff, res_granted_in;
   vra_pkg::outcome_type       res_outcome_ff, res_outcome_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [vra_pkg::ADDR_W-1:0] rsp_granted_ff, rsp_granted_in;
   vra_pkg::outcome_type       rsp_outcome_ff, rsp_outcome_in;
   logic [vra_pkg::ADDR_W-1:0] area_base_ff;
   logic [vra_pkg::ADDR_W-1:0] area_end_ff;

   vra_pkg::range_type         mem [RANGE_SLOTS];
   vra_pkg::range_type         rd_data_ff;
   logic [IDX_W-1:0]           rd_addr;
   logic                       mem_we;
   logic [IDX_W-1:0]           mem_waddr;
   vra_pkg::range_type         mem_wdata;

   vra_pkg::check_type         chk;
   logic                       req_take;
   logic [vra_pkg::ADDR_W-1:0] req_span;
   logic [CNT_W-1:0]           last_cnt;

   assign req_chan.ready           = state_ff == ST_IDLE;
   assign req_take                 = req_chan.valid && req_chan.ready;
   assign req_span                 = span_of(req_chan.request_length);
   assign last_cnt                 = live_ff - CNT_W'(1);
   assign csr_chan.ready           = 1'b1;
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.granted_address = rsp_granted_ff;
   assign rsp_chan.outcome         = rsp_outcome_ff;

   vra_entry_check u_check (
      .entry (rd_data_ff),
      .kind  (kind_ff),
      .span  (span_ff),
      .addr  (addr_ff),
      .after (after_ff),
      .chk   (chk)
   );

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      span_in        = span_ff;
      addr_in        = addr_ff;
      after_in       = after_ff;
      live_in        = live_ff;
      loaded_in      = loaded_ff;
      scan_in        = scan_ff;
      chk_valid_in   = 1'b0;
      chk_idx_in     = chk_idx_ff;
      hit_idx_in     = hit_idx_ff;
      res_granted_in = res_granted_ff;
      res_outcome_in = res_outcome_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_granted_in = rsp_granted_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rd_addr        = scan_ff[IDX_W-1:0];
      mem_we         = 1'b0;
      mem_waddr      = chk_idx_ff;
      mem_wdata      = chk.updated;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               kind_in  = req_chan.kind;
               span_in  = req_span;
               addr_in  = req_chan.release_address;
               after_in = req_chan.release_address + req_span;
               scan_in  = '0;
               state_in = ST_SCAN;
               if (!loaded_ff) begin
                  mem_we           = 1'b1;
                  mem_waddr        = '0;
                  mem_wdata.start  = area_base_ff;
                  mem_wdata.length = area_end_ff - area_base_ff;
                  live_in          = CNT_W'(1);
                  loaded_in        = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            // issue the next read while the previous entry is checked
            if (scan_ff < live_ff) begin
               chk_valid_in = 1'b1;
               chk_idx_in   = scan_ff[IDX_W-1:0];
               scan_in      = scan_ff + CNT_W'(1);
            end
            if (chk_valid_ff && chk.hit) begin
               chk_valid_in = 1'b0;
               state_in     = ST_DONE;
               if (kind_ff == vra_pkg::KIND_RESERVE) begin
                  res_granted_in = rd_data_ff.start;
                  res_outcome_in = vra_pkg::OUT_RESERVED;
                  if (chk.empties && CNT_W'(chk_idx_ff) != last_cnt) begin
                     hit_idx_in = chk_idx_ff;
                     state_in   = ST_MOVE_RD;
                  end else if (chk.empties) begin
                     live_in = last_cnt;
                  end else begin
                     mem_we = 1'b1;
                  end
               end else begin
                  mem_we         = 1'b1;
                  res_granted_in = '0;
                  res_outcome_in = vra_pkg::OUT_MERGED;
               end
            end else if (!chk_valid_ff && scan_ff >= live_ff) begin
               state_in       = ST_DONE;
               res_granted_in = '0;
               if (kind_ff == vra_pkg::KIND_RESERVE) begin
                  res_outcome_in = vra_pkg::OUT_NO_SPACE;
               end else if (live_ff < CNT_W'(RANGE_SLOTS)) begin
                  mem_we           = 1'b1;
                  mem_waddr        = live_ff[IDX_W-1:0];
                  mem_wdata.start  = addr_ff;
                  mem_wdata.length = span_ff;
                  live_in          = live_ff + CNT_W'(1);
                  res_outcome_in   = vra_pkg::OUT_APPENDED;
               end else begin
                  res_outcome_in = vra_pkg::OUT_LEAKED;
               end
            end
         end
         ST_MOVE_RD: begin
            rd_addr  = last_cnt[IDX_W-1:0];
            state_in = ST_MOVE_WR;
         end
         ST_MOVE_WR: begin
            // fill the emptied slot with the last live range
            mem_we    = 1'b1;
            mem_waddr = hit_idx_ff;
            mem_wdata = rd_data_ff;
            live_in   = last_cnt;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = res_granted_ff;
               rsp_outcome_in = res_outcome_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         live_ff      <= '0;
         loaded_ff    <= 1'b0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         loaded_ff    <= loaded_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff        <= kind_in;
      span_ff        <= span_in;
      addr_ff        <= addr_in;
      after_ff       <= after_in;
      scan_ff        <= scan_in;
      chk_idx_ff     <= chk_idx_in;
      hit_idx_ff     <= hit_idx_in;
      res_granted_ff <= res_granted_in;
      res_outcome_ff <= res_outcome_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_outcome_ff <= rsp_outcome_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         area_base_ff <= vra_pkg::AREA_BASE_RST;
         area_end_ff  <= vra_pkg::AREA_END_RST;
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            vra_pkg::CSR_AREA_BASE: area_base_ff <= csr_chan.data;
            vra_pkg::CSR_AREA_END:  area_end_ff  <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // scan is read-only; the table load lands before it and all other writes after it, so no forwarding is needed
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assert property (@(posedge clock) disable iff (reset)
      live_ff <= CNT_W'(RANGE_SLOTS))
      else $error("live range count exceeds table depth");

   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> CNT_W'(mem_waddr) <= live_ff)
      else $error("table write beyond the live ranges");

   assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_SCAN && loaded_ff && live_ff != '0 ||
                   state_ff == ST_SCAN && loaded_ff && kind_ff == vra_pkg::KIND_RESERVE ||
                   state_ff == ST_SCAN && loaded_ff && kind_ff == vra_pkg::KIND_RELEASE)
      else $error("accepted request did not start a loaded scan");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_outcome_ff != vra_pkg::OUT_RESERVED |-> rsp_granted_ff == '0)
      else $error("nonzero address on a failed reserve or a release");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MOVE_WR |-> $past(state_ff) == ST_MOVE_RD)
      else $error("entry move written without its read");

endmodule

FILE: design/vra_entry_check.sv
module vra_entry_check (
   input  vra_pkg::range_type           entry,
   input  logic                         kind,
   input  logic [vra_pkg::ADDR_W-1:0]   span,
   input  logic [vra_pkg::ADDR_W-1:0]   addr,
   input  logic [vra_pkg::ADDR_W-1:0]   after,
   output vra_pkg::check_type           chk
);

   logic                       fits;
   logic                       front;
   logic                       back;
   logic [vra_pkg::ADDR_W-1:0] entry_end;

   assign fits      = entry.length >= span;
   assign entry_end = entry.start + entry.length;
   assign front     = entry.start == after;
   assign back      = entry_end == addr;

   always_comb begin
      if (kind == vra_pkg::KIND_RESERVE) begin
         // carve the span off the front of the range
         chk.hit            = fits;
         chk.empties        = entry.length == span;
         chk.updated.start  = entry.start + span;
         chk.updated.length = entry.length - span;
      end else begin
         // front match takes priority over a back match on the same entry
         chk.hit            = front || back;
         chk.empties        = 1'b0;
         chk.updated.start  = front ? addr : entry.start;
         chk.updated.length = entry.length + span;
      end
   end

endmodule

FILE: bench/tb_top.sv
module tb_top;

   localparam int TABLE_DEPTH     = vra_pkg::RANGE_SLOTS_DEF;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int QUEUE_AHEAD     = 4;

   // indexes that map to no register
   localparam logic [vra_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED_A = 2'd2;
   localparam logic [vra_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED_B = 2'd3;

   // area that wraps through address zero: 64 pages below the top, 64 MiB above
   localparam logic [vra_pkg::ADDR_W-1:0] WRAP_BASE = 48'hFFFF_FFFC_0000;
   localparam logic [vra_pkg::ADDR_W-1:0] WRAP_END  = 48'h0000_0400_0000;
   localparam logic [vra_pkg::LEN_W-1:0]  WHOLE_LEN = 34'h0_0403_F000;
   localparam logic [vra_pkg::LEN_W-1:0]  LEN_MAX   = '1;

   typedef struct packed {
      vra_pkg::kind_type          kind;
      logic [vra_pkg::LEN_W-1:0]  length;
      logic [vra_pkg::ADDR_W-1:0] address;
   } request_type;

   typedef struct packed {
      logic [vra_pkg::ADDR_W-1:0] granted;
      vra_pkg::outcome_type       outcome;
   } answer_type;

   typedef struct packed {
      logic [vra_pkg::ADDR_W-1:0] address;
      logic [vra_pkg::LEN_W-1:0]  length;
   } grant_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vra_req_if req_chan();
   vra_rsp_if rsp_chan();
   vra_csr_if csr_chan();

   virtual_range_allocator uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow of the free-range table
   logic [vra_pkg::ADDR_W-1:0] free_start [TABLE_DEPTH];
   logic [vra_pkg::ADDR_W-1:0] free_len   [TABLE_DEPTH];
   int                         free_count  = 0;
   bit                         table_ready = 1'b0;
   logic [vra_pkg::ADDR_W-1:0] area_base_q = vra_pkg::AREA_BASE_RST;
   logic [vra_pkg::ADDR_W-1:0] area_end_q  = vra_pkg::AREA_END_RST;

   request_type pending_requests [$];
   answer_type  expected_answers [$];
   grant_type   granted_pool [$];
   request_type offered;
   answer_type  predicted;
   answer_type  want;

   int mismatches    = 0;
   int src_idle_pct  = 18;
   int sink_idle_pct = 18;
   int hold_orders   = 0;
   int holds_served  = 0;
   int hold_left     = 0;

   task automatic report_mismatch(string what);
      if (mismatches < 40)
         $display("tb_top mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   function automatic answer_type predict_answer(request_type rq);
      logic [vra_pkg::ADDR_W-1:0] span;
      logic [vra_pkg::ADDR_W-1:0] after;
      logic [63:0]                pages;
      answer_type                 ans;
      bit                         done;
      int                         last;
      if (!table_ready) begin
         free_start[0] = area_base_q;
         free_len[0]   = area_end_q - area_base_q;
         free_count    = 1;
         table_ready   = 1'b1;
      end
      pages = (64'(rq.length) + 64'(vra_pkg::PAGE_BYTES) - 64'd1) / 64'(vra_pkg::PAGE_BYTES);
      span  = vra_pkg::ADDR_W'(pages * 64'(vra_pkg::PAGE_BYTES) + 64'(vra_pkg::PAGE_BYTES));
      after = rq.address + span;
      ans.granted = '0;
      done = 1'b0;
      if (rq.kind == vra_pkg::KIND_RESERVE) begin
         ans.outcome = vra_pkg::OUT_NO_SPACE;
         for (int i = 0; i < free_count && !done; i++) begin
            if (free_len[i] >= span) begin
               done          = 1'b1;
               ans.granted   = free_start[i];
               ans.outcome   = vra_pkg::OUT_RESERVED;
               free_start[i] = free_start[i] + span;
               free_len[i]   = free_len[i] - span;
               if (free_len[i] == '0) begin
                  // refill the hole from the tail
                  last          = free_count - 1;
                  free_start[i] = free_start[last];
                  free_len[i]   = free_len[last];
                  free_count    = last;
               end
            end
         end
      end else begin
         for (int i = 0; i < free_count && !done; i++) begin
            if (free_start[i] == after) begin
               done          = 1'b1;
               free_start[i] = rq.address;
               free_len[i]   = free_len[i] + span;
            end else if (vra_pkg::ADDR_W'(free_start[i] + free_len[i]) == rq.address) begin
               done        = 1'b1;
               free_len[i] = free_len[i] + span;
            end
         end
         if (done) begin
            ans.outcome = vra_pkg::OUT_MERGED;
         end else if (free_count < TABLE_DEPTH) begin
            free_start[free_count] = rq.address;
            free_len[free_count]   = span;
            free_count++;
            ans.outcome = vra_pkg::OUT_APPENDED;
         end else begin
            ans.outcome = vra_pkg::OUT_LEAKED;
         end
      end
      return ans;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predicted = predict_answer(offered);
            expected_answers.push_back(predicted);
            if (predicted.outcome == vra_pkg::OUT_RESERVED)
               granted_pool.push_back('{predicted.granted, offered.length});
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
               offered = pending_requests.pop_front();
               req_chan.valid           <= 1'b1;
               req_chan.kind            <= offered.kind;
               req_chan.request_length  <= offered.length;
               req_chan.release_address <= offered.address;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= 0;
         holds_served   <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_answers.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction, granted %h outcome %0d",
                                         rsp_chan.granted_address, rsp_chan.outcome));
            end else begin
               want = expected_answers.pop_front();
               if (rsp_chan.granted_address !== want.granted)
                  report_mismatch($sformatf("granted_address %h, predicted %h",
                                            rsp_chan.granted_address, want.granted));
               if (rsp_chan.outcome !== want.outcome)
                  report_mismatch($sformatf("outcome %0d, predicted %s",
                                            rsp_chan.outcome, want.outcome.name()));
            end
         end
         if (holds_served != hold_orders) begin
            holds_served   <= hold_orders;
            hold_left      <= RSP_HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left      <= hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   task automatic write_area(logic [vra_pkg::CSR_INDEX_W-1:0] idx,
                             logic [vra_pkg::ADDR_W-1:0] value);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      if (idx == vra_pkg::CSR_AREA_BASE)
         area_base_q = value;
      else if (idx == vra_pkg::CSR_AREA_END)
         area_end_q = value;
   endtask

   task automatic offer(request_type rq);
      do @(negedge clock); while (pending_requests.size() >= QUEUE_AHEAD);
      pending_requests.push_back(rq);
   endtask

   // hold until the block has answered everything
   task automatic drain();
      do @(negedge clock);
      while (pending_requests.size() != 0 || expected_answers.size() != 0 || req_chan.valid);
   endtask

   function automatic request_type draw_request(int noise_pct);
      request_type rq;
      int          pick;
      rq.kind    = vra_pkg::KIND_RESERVE;
      rq.address = {16'($urandom), 32'($urandom)};
      case ($urandom_range(9))
         0:       rq.length = {2'($urandom), 32'($urandom)};
         1:       rq.length = vra_pkg::LEN_W'($urandom_range(1 << 20));
         2:       rq.length = vra_pkg::LEN_W'($urandom_range(16, 1) * vra_pkg::PAGE_BYTES);
         default: rq.length = vra_pkg::LEN_W'($urandom_range(8 * vra_pkg::PAGE_BYTES));
      endcase
      if ($urandom_range(99) < noise_pct) begin
         rq.kind = vra_pkg::KIND_RELEASE;
         if ($urandom_range(1))
            rq.address[vra_pkg::PAGE_SHIFT-1:0] = '0;
      end else if (granted_pool.size() != 0 && $urandom_range(1)) begin
         // give back a live reservation exactly as it was taken
         pick       = $urandom_range(granted_pool.size() - 1);
         rq.kind    = vra_pkg::KIND_RELEASE;
         rq.address = granted_pool[pick].address;
         rq.length  = granted_pool[pick].length;
         granted_pool.delete(pick);
      end
      return rq;
   endfunction

   task automatic run_phase(int count, int noise_pct, int src_pct, int sink_pct, bit hold);
      src_idle_pct  = src_pct;
      sink_idle_pct = sink_pct;
      if (hold)
         hold_orders++;
      repeat (count) offer(draw_request(noise_pct));
      drain();
   endtask

   initial begin
      req_chan.valid           = 1'b0;
      req_chan.kind            = vra_pkg::KIND_RESERVE;
      req_chan.request_length  = '0;
      req_chan.release_address = '0;
      rsp_chan.ready           = 1'b0;
      csr_chan.valid           = 1'b0;
      csr_chan.index           = vra_pkg::CSR_AREA_BASE;
      csr_chan.data            = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      write_area(vra_pkg::CSR_AREA_BASE, '0);
      write_area(vra_pkg::CSR_AREA_END, '1);
      write_area(CSR_UNMAPPED_A, 48'h1234_5678_9ABC);
      write_area(CSR_UNMAPPED_B, '1);
      write_area(vra_pkg::CSR_AREA_BASE, WRAP_BASE);
      write_area(vra_pkg::CSR_AREA_END, WRAP_END);

      // take the whole area, then work on an empty table
      offer('{vra_pkg::KIND_RESERVE, WHOLE_LEN, 48'hFFFF_FFFF_FFFF});
      offer('{vra_pkg::KIND_RESERVE, 34'd0, 48'd0});
      offer('{vra_pkg::KIND_RELEASE, WHOLE_LEN, WRAP_BASE});
      // the second reservation lands on address zero
      offer('{vra_pkg::KIND_RESERVE, 34'h3F000, 48'd0});
      offer('{vra_pkg::KIND_RESERVE, 34'd1, 48'd0});
      offer('{vra_pkg::KIND_RESERVE, LEN_MAX, 48'd0});
      offer('{vra_pkg::KIND_RELEASE, 34'd1, 48'd0});
      offer('{vra_pkg::KIND_RELEASE, 34'h3F000, WRAP_BASE});
      offer('{vra_pkg::KIND_RELEASE, 34'd0, 48'hFFFF_FFFF_F000});
      offer('{vra_pkg::KIND_RELEASE, 34'd0, WRAP_END});
      offer('{vra_pkg::KIND_RELEASE, LEN_MAX, 48'hFFFF_FFFF_FFFF});
      offer('{vra_pkg::KIND_RELEASE, 34'h2_AAAA_AAAA, 48'd0});
      offer('{vra_pkg::KIND_RELEASE, 34'h1_5555_5555, 48'h5555_5555_5555});
      offer('{vra_pkg::KIND_RELEASE, 34'h2_AAAA_AAAA, 48'hAAAA_AAAA_AAAA});
      offer('{vra_pkg::KIND_RESERVE, 34'h1_5555_5555, 48'h5555_5555_5555});
      offer('{vra_pkg::KIND_RESERVE, 34'h2_AAAA_AAAA, 48'hAAAA_AAAA_AAAA});
      offer('{vra_pkg::KIND_RESERVE, 34'(vra_pkg::PAGE_BYTES), 48'd0});
      offer('{vra_pkg::KIND_RESERVE, 34'(vra_pkg::PAGE_BYTES - 1), 48'd0});
      drain();
      // forget the grants taken above, so random releases draw only on later ones
      granted_pool.delete();

      // loaded table must ignore these
      write_area(vra_pkg::CSR_AREA_BASE, '1);
      write_area(vra_pkg::CSR_AREA_END, '0);
      run_phase(150, 10, 18, 18, 1'b1);

      write_area(vra_pkg::CSR_AREA_BASE, '0);
      write_area(vra_pkg::CSR_AREA_END, 48'h0000_0001_0000);
      // mostly stray releases: fill the table until spans leak
      run_phase(100, 75, 18, 18, 1'b0);

      run_phase(60, 10, 0, 0, 1'b0);

      write_area(vra_pkg::CSR_AREA_BASE, 48'h8000_0000_0000);
      write_area(vra_pkg::CSR_AREA_END, '1);
      run_phase(100, 15, 18, 18, 1'b1);

      repeat (200) @(posedge clock);
      if (mismatches == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
